FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define A2O_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("a2o assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define A2O_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("a2o assertion failed");

`endif

FILE: hdl/a2o_pkg.sv
// Shared types, constants and helpers for the AABB-to-OBB transform unit.
// No dependencies.
`default_nettype none

package a2o_pkg;

    localparam int FRAC_BITS = 16;
    localparam int REG_IDX_W = 3;
    localparam int REG_W     = 64;
    localparam int NUM_REGS  = 6;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ROW0_XY   = 3'd0,
        REG_ROW1_XY   = 3'd1,
        REG_ROW2_XY   = 3'd2,
        REG_TRANS_XY  = 3'd3,
        REG_ROWS01_Z  = 3'd4,
        REG_ROWS23_Z  = 3'd5
    } reg_idx_t;

    typedef logic signed [31:0] word_t;
    typedef word_t [2:0]        vec3_t;
    // mat[row][col], row 3 is the translation
    typedef vec3_t [3:0]        mat_t;

    typedef struct packed {
        logic [31:0] len;
        vec3_t       dir;
    } axis_info_t;

    typedef axis_info_t [2:0] axis_tab_t;

    typedef struct packed {
        logic        vld;
        logic [1:0]  axis;
        vec3_t       lo;
        vec3_t       hi;
    } issue_t;

    typedef struct packed {
        logic        vld;
        logic [1:0]  axis;
        word_t       origin;
        vec3_t       dir;
        word_t       extent;
        logic        degen;
        logic        last;
    } result_t;

    // Magnitude of a signed word as an unsigned 32-bit value.
    function automatic logic [31:0] mag32(input word_t w);
        logic [31:0] u;
        u = w;
        return w[31] ? (~u + 32'd1) : u;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/aabb_to_obb_transform_unit.sv
// Top level of the AABB-to-OBB transform: config registers, axis issue, pipeline.
// Depends on a2o_pkg, a2o_axis_pre, a2o_axis_pipe and assert_macros.svh.
//
// Channel   | Signals                                   | Handshake
// ----------+-------------------------------------------+-------------------------
// request   | min_x..min_z, max_x..max_z                | start & !busy
// result    | axis_index, origin_part, dir_*, extent,   | result_valid, one cycle
//           | degenerate, last                          |
// config    | wr_index, wr_data                         | wr_en, no wait
//
// A box is latched on acceptance and issued as three axis passes back to back; busy
// holds through the first two, so the next box may be accepted while the third issues.
// Each pass runs through the issue register and the stage 1-3 and result registers;
// a box's three results leave in a row. After each config write busy holds while
// the serial square root and divider rebuild the axis lengths and directions.
// Reset clears the registers to zero: all axes read as degenerate.
// The receiver cannot stall; nothing inside ever waits on the output.
`default_nettype none

module aabb_to_obb_transform_unit
    import a2o_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic signed [31:0]   min_x,
    input  wire logic signed [31:0]   min_y,
    input  wire logic signed [31:0]   min_z,
    input  wire logic signed [31:0]   max_x,
    input  wire logic signed [31:0]   max_y,
    input  wire logic signed [31:0]   max_z,
    input  wire logic                 wr_en,
    input  wire logic [REG_IDX_W-1:0] wr_index,
    input  wire logic [REG_W-1:0]     wr_data,
    output logic                      result_valid,
    output logic [1:0]                axis_index,
    output logic signed [31:0]        origin_part,
    output logic signed [31:0]        dir_x,
    output logic signed [31:0]        dir_y,
    output logic signed [31:0]        dir_z,
    output logic signed [31:0]        extent,
    output logic                      degenerate,
    output logic                      last
);

`include "assert_macros.svh"

    logic [NUM_REGS-1:0][REG_W-1:0] cfg_reg;
    mat_t       mat;
    issue_t     iss_reg;
    axis_tab_t  info;
    logic       pre_busy;
    logic       accept;
    result_t    res;

    // Hold the register file; ignore writes past the last register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx_t'(wr_index))
                REG_ROW0_XY:  cfg_reg[REG_ROW0_XY]  <= wr_data;
                REG_ROW1_XY:  cfg_reg[REG_ROW1_XY]  <= wr_data;
                REG_ROW2_XY:  cfg_reg[REG_ROW2_XY]  <= wr_data;
                REG_TRANS_XY: cfg_reg[REG_TRANS_XY] <= wr_data;
                REG_ROWS01_Z: cfg_reg[REG_ROWS01_Z] <= wr_data;
                REG_ROWS23_Z: cfg_reg[REG_ROWS23_Z] <= wr_data;
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Unpack the registers into the 4x3 matrix, row 3 being the translation.
    always_comb
    begin
        mat[0][0] = cfg_reg[REG_ROW0_XY][31:0];
        mat[0][1] = cfg_reg[REG_ROW0_XY][63:32];
        mat[1][0] = cfg_reg[REG_ROW1_XY][31:0];
        mat[1][1] = cfg_reg[REG_ROW1_XY][63:32];
        mat[2][0] = cfg_reg[REG_ROW2_XY][31:0];
        mat[2][1] = cfg_reg[REG_ROW2_XY][63:32];
        mat[3][0] = cfg_reg[REG_TRANS_XY][31:0];
        mat[3][1] = cfg_reg[REG_TRANS_XY][63:32];
        mat[0][2] = cfg_reg[REG_ROWS01_Z][31:0];
        mat[1][2] = cfg_reg[REG_ROWS01_Z][63:32];
        mat[2][2] = cfg_reg[REG_ROWS23_Z][31:0];
        mat[3][2] = cfg_reg[REG_ROWS23_Z][63:32];
    end

    // Lengths and directions depend on the matrix alone: rebuild them after writes.
    a2o_axis_pre u_pre (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (wr_en),
        .mat     (mat),
        .busy    (pre_busy),
        .info    (info)
    );

    // Stay busy through axes 0 and 1; the next box may enter while axis 2 issues.
    assign busy   = pre_busy | wr_en | (iss_reg.vld & (iss_reg.axis != 2'd2));
    assign accept = start & ~busy;

    // Latch the box and step the axis counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_reg <= '0;
        end
        else if (accept)
        begin
            iss_reg.vld   <= 1'b1;
            iss_reg.axis  <= '0;
            iss_reg.lo[0] <= min_x;
            iss_reg.lo[1] <= min_y;
            iss_reg.lo[2] <= min_z;
            iss_reg.hi[0] <= max_x;
            iss_reg.hi[1] <= max_y;
            iss_reg.hi[2] <= max_z;
        end
        else if (iss_reg.vld)
        begin
            if (iss_reg.axis == 2'd2)
            begin
                iss_reg.vld <= 1'b0;
            end
            else
            begin
                iss_reg.axis <= iss_reg.axis + 2'd1;
            end
        end
    end

    a2o_axis_pipe u_pipe (
        .clk   (clk),
        .rst_n (rst_n),
        .iss   (iss_reg),
        .mat   (mat),
        .info  (info),
        .res   (res)
    );

    assign result_valid = res.vld;
    assign axis_index   = res.axis;
    assign origin_part  = res.origin;
    assign dir_x        = res.dir[0];
    assign dir_y        = res.dir[1];
    assign dir_z        = res.dir[2];
    assign extent       = res.extent;
    assign degenerate   = res.degen;
    assign last         = res.last;

    // A box's three results come out back to back, in axis order.
    `A2O_ASSERT_NEXT(a_axis_order, result_valid && (axis_index == 2'd0),
                     result_valid && (axis_index == 2'd1))
    `A2O_ASSERT_NOW(a_last_run, result_valid && last,
                    $past(result_valid) && $past(result_valid, 2))
    // An accepted request blocks the next cycle.
    `A2O_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // A zero-length axis carries a zero direction and zero extent.
    `A2O_ASSERT_NOW(a_degen_zero, result_valid && degenerate,
                    (dir_x == 32'sd0) && (dir_y == 32'sd0) && (dir_z == 32'sd0) &&
                    (extent == 32'sd0))

endmodule

`default_nettype wire

FILE: hdl/a2o_axis_pre.sv
// Per-axis length and unit direction, recomputed from the matrix after each write.
// Depends on a2o_pkg: bit-serial square root and restoring division.
`default_nettype none

module a2o_axis_pre
    import a2o_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      restart,
    input  wire mat_t      mat,
    output logic           busy,
    output axis_tab_t      info
);

    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(31);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(FRAC_BITS);

    typedef enum logic [1:0] {PRE_IDLE, PRE_SQUARE, PRE_SQRT, PRE_DIV} pre_state_t;

    pre_state_t           state_reg;
    logic [1:0]           k_reg;
    logic [1:0]           j_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [63:0]          prod_reg;
    logic [63:0]          acc_reg;
    logic [33:0]          rem_reg;
    logic [31:0]          root_reg;
    logic [33:0]          drem_reg;
    logic [FRAC_BITS:0]   q_reg;
    axis_tab_t            info_reg;

    logic [1:0]           sq_col;
    logic [31:0]          sq_mag;
    logic [63:0]          prod_next;
    logic [35:0]          rem_trial;
    logic [35:0]          trial;
    logic                 sq_ge;
    logic [33:0]          rem_next;
    logic [31:0]          root_next;
    logic [31:0]          len_cur;
    logic                 d_ge;
    logic [33:0]          d_sub;
    logic [33:0]          drem_next;
    logic [FRAC_BITS:0]   q_next;
    logic [31:0]          q_word;
    word_t                dir_next;
    logic [1:0]           next_col;

    always_comb
    begin
        sq_col    = (j_reg == 2'd3) ? 2'd0 : j_reg;
        sq_mag    = mag32(mat[k_reg][sq_col]);
        prod_next = 64'(sq_mag) * 64'(sq_mag);

        // one result bit per step, two radicand bits consumed
        rem_trial = {rem_reg, acc_reg[63:62]};
        trial     = {2'b00, root_reg, 2'b01};
        sq_ge     = rem_trial >= trial;
        rem_next  = sq_ge ? 34'(rem_trial - trial) : 34'(rem_trial);
        root_next = {root_reg[30:0], sq_ge};

        len_cur   = info_reg[k_reg].len;
        d_ge      = drem_reg >= {2'b00, len_cur};
        d_sub     = d_ge ? (drem_reg - {2'b00, len_cur}) : drem_reg;
        drem_next = {d_sub[32:0], 1'b0};
        q_next    = {q_reg[FRAC_BITS-1:0], d_ge};
        q_word    = {{(31-FRAC_BITS){1'b0}}, q_next};
        if (len_cur == 32'd0)
        begin
            dir_next = '0;
        end
        else if (mat[k_reg][j_reg][31])
        begin
            dir_next = word_t'(~q_word + 32'd1);
        end
        else
        begin
            dir_next = word_t'(q_word);
        end
        next_col  = (j_reg == 2'd2) ? 2'd0 : (j_reg + 2'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PRE_IDLE;
            k_reg     <= '0;
            j_reg     <= '0;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            info_reg  <= '0;
        end
        else if (restart)
        begin
            state_reg <= PRE_SQUARE;
            k_reg     <= '0;
            j_reg     <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                PRE_IDLE:
                begin
                    state_reg <= PRE_IDLE;
                end
                PRE_SQUARE:
                begin
                    prod_reg <= prod_next;
                    if (j_reg != 2'd0)
                    begin
                        acc_reg <= acc_reg + prod_reg;
                    end
                    if (j_reg == 2'd3)
                    begin
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= '0;
                        j_reg     <= '0;
                        state_reg <= PRE_SQRT;
                    end
                    else
                    begin
                        j_reg <= j_reg + 2'd1;
                    end
                end
                PRE_SQRT:
                begin
                    rem_reg  <= rem_next;
                    root_reg <= root_next;
                    acc_reg  <= {acc_reg[61:0], 2'b00};
                    cnt_reg  <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == SQRT_LAST)
                    begin
                        info_reg[k_reg].len <= root_next;
                        j_reg     <= '0;
                        drem_reg  <= {2'b00, mag32(mat[k_reg][0])};
                        q_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= PRE_DIV;
                    end
                end
                PRE_DIV:
                begin
                    drem_reg <= drem_next;
                    q_reg    <= q_next;
                    cnt_reg  <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == DIV_LAST)
                    begin
                        info_reg[k_reg].dir[j_reg] <= dir_next;
                        cnt_reg <= '0;
                        q_reg   <= '0;
                        drem_reg <= {2'b00, mag32(mat[k_reg][next_col])};
                        if (j_reg == 2'd2)
                        begin
                            j_reg <= '0;
                            if (k_reg == 2'd2)
                            begin
                                state_reg <= PRE_IDLE;
                            end
                            else
                            begin
                                k_reg     <= k_reg + 2'd1;
                                acc_reg   <= '0;
                                state_reg <= PRE_SQUARE;
                            end
                        end
                        else
                        begin
                            j_reg <= next_col;
                        end
                    end
                end
                default:
                begin
                    state_reg <= PRE_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != PRE_IDLE);
    assign info = info_reg;

endmodule

`default_nettype wire

FILE: hdl/a2o_axis_pipe.sv
// Four-stage per-axis datapath: select, multiply, sum and clamp, saturate.
// Depends on a2o_pkg.
`default_nettype none

module a2o_axis_pipe
    import a2o_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire issue_t    iss,
    input  wire mat_t      mat,
    input  wire axis_tab_t info,
    output result_t        res
);

    localparam int SUM_W = 66 - FRAC_BITS;
    localparam int TRM_W = 64 - FRAC_BITS;
    localparam int PE_W  = 65 - FRAC_BITS;

    // stage 1
    logic               s1_vld_reg;
    logic [1:0]         s1_axis_reg;
    logic [2:0][31:0]   s1_a_reg;
    logic [2:0][31:0]   s1_b_reg;
    logic [2:0]         s1_neg_reg;
    word_t              s1_tr_reg;
    logic [32:0]        s1_size_reg;
    logic               s1_sneg_reg;
    logic [31:0]        s1_len_reg;
    vec3_t              s1_dir_reg;
    // stage 2
    logic               s2_vld_reg;
    logic [1:0]         s2_axis_reg;
    logic [2:0][63:0]   s2_p_reg;
    logic [2:0]         s2_neg_reg;
    word_t              s2_tr_reg;
    logic [64:0]        s2_pe_reg;
    logic               s2_sneg_reg;
    logic               s2_degen_reg;
    vec3_t              s2_dir_reg;
    // stage 3
    logic               s3_vld_reg;
    logic [1:0]         s3_axis_reg;
    logic signed [SUM_W-1:0] s3_origin_reg;
    word_t              s3_extent_reg;
    logic               s3_degen_reg;
    vec3_t              s3_dir_reg;
    // output
    result_t            res_reg;

    logic [1:0]         k_sel;
    logic signed [32:0] diff;
    logic signed [SUM_W-1:0] origin_next;
    logic [TRM_W-1:0]   term;
    logic [PE_W-1:0]    pe_sh;
    logic               pe_big;
    word_t              extent_next;
    logic [SUM_W-32:0]  hi_bits;
    word_t              origin_sat;

    always_comb
    begin
        k_sel = (iss.axis == 2'd3) ? 2'd0 : iss.axis;
        diff  = 33'(signed'({iss.hi[k_sel][31], iss.hi[k_sel]}))
              - 33'(signed'({iss.lo[k_sel][31], iss.lo[k_sel]}));
    end

    // stage 1: pick operands for this axis, split sign and magnitude
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= iss.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_axis_reg <= k_sel;
        for (int j = 0; j < 3; j++)
        begin
            s1_a_reg[j]   <= mag32(iss.lo[j]);
            s1_b_reg[j]   <= mag32(mat[j][k_sel]);
            s1_neg_reg[j] <= iss.lo[j][31] ^ mat[j][k_sel][31];
        end
        s1_tr_reg   <= mat[3][k_sel];
        s1_sneg_reg <= diff[32];
        s1_size_reg <= diff[32] ? 33'(-diff) : 33'(diff);
        s1_len_reg  <= info[k_sel].len;
        s1_dir_reg  <= info[k_sel].dir;
    end

    // stage 2: multiply
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_axis_reg <= s1_axis_reg;
        for (int j = 0; j < 3; j++)
        begin
            s2_p_reg[j] <= 64'(s1_a_reg[j]) * 64'(s1_b_reg[j]);
        end
        s2_neg_reg   <= s1_neg_reg;
        s2_tr_reg    <= s1_tr_reg;
        s2_pe_reg    <= 65'(s1_size_reg) * 65'(s1_len_reg);
        s2_sneg_reg  <= s1_sneg_reg;
        s2_degen_reg <= (s1_len_reg == 32'd0);
        s2_dir_reg   <= s1_dir_reg;
    end

    // stage 3: truncate products toward zero, sum origin, clamp extent
    always_comb
    begin
        origin_next = {{(SUM_W-32){s2_tr_reg[31]}}, s2_tr_reg};
        for (int j = 0; j < 3; j++)
        begin
            term = s2_p_reg[j][63:FRAC_BITS];
            if (s2_neg_reg[j])
            begin
                origin_next = origin_next - signed'({2'b00, term});
            end
            else
            begin
                origin_next = origin_next + signed'({2'b00, term});
            end
        end
        pe_sh  = s2_pe_reg[64:FRAC_BITS];
        pe_big = |pe_sh[PE_W-1:31];
        if (s2_sneg_reg)
        begin
            extent_next = pe_big ? word_t'(32'h8000_0000) : word_t'(~pe_sh[31:0] + 32'd1);
        end
        else
        begin
            extent_next = pe_big ? word_t'(32'h7fff_ffff) : word_t'(pe_sh[31:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_axis_reg   <= s2_axis_reg;
        s3_origin_reg <= origin_next;
        s3_extent_reg <= extent_next;
        s3_degen_reg  <= s2_degen_reg;
        s3_dir_reg    <= s2_dir_reg;
    end

    // stage 4: saturate origin, drive the result
    always_comb
    begin
        hi_bits = s3_origin_reg[SUM_W-1:31];
        if ((&hi_bits) || !(|hi_bits))
        begin
            origin_sat = word_t'(s3_origin_reg[31:0]);
        end
        else if (s3_origin_reg[SUM_W-1])
        begin
            origin_sat = word_t'(32'h8000_0000);
        end
        else
        begin
            origin_sat = word_t'(32'h7fff_ffff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg.vld    <= s3_vld_reg;
            res_reg.axis   <= s3_axis_reg;
            res_reg.origin <= origin_sat;
            res_reg.dir    <= s3_dir_reg;
            res_reg.extent <= s3_extent_reg;
            res_reg.degen  <= s3_degen_reg;
            res_reg.last   <= (s3_axis_reg == 2'd2);
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire
